// File: sv/biquad_iir_filter_top_assert.svh
// Assertion macros for the biquad filter top level.
`ifndef BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
`define BIQUAD_IIR_FILTER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is high.
`define BQD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, disabled while reset is high.
`define BQD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BQD_ASSERT_NOW(label, clk, rst, ante, cons, msg)
`define BQD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// File: sv/bqd_pkg.sv
// Shared constants and types for the biquad filter.
package bqd_pkg;

   localparam int GAIN_BITS      = 24;
   localparam int GAIN_FRAC      = 20;
   localparam int HIST_GUARD     = 8;
   localparam int COEF_INT_BITS  = 4;
   localparam int CSR_INDEX_BITS = 3;

   localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(1) << GAIN_FRAC;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_FILTER_ON = 3'd0,
      REG_COEF_B0   = 3'd1,
      REG_COEF_B1   = 3'd2,
      REG_COEF_B2   = 3'd3,
      REG_COEF_A1   = 3'd4,
      REG_COEF_A2   = 3'd5,
      REG_OUT_GAIN  = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      TERM_B0 = 3'd0,
      TERM_B1 = 3'd1,
      TERM_B2 = 3'd2,
      TERM_A1 = 3'd3,
      TERM_A2 = 3'd4
   } term_type;

   // Accumulator command, applied to the product registered in the previous cycle.
   typedef struct packed {
      logic clear;
      logic add;
      logic sub;
   } mac_ctl_type;

endpackage

// File: sv/bqd_if.sv
// Sample stream interfaces for the biquad filter request and response channels.
interface bqd_req_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface bqd_rsp_if #(parameter int SAMPLE_BITS = 24);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

// File: sv/bqd_mac.sv
// Shared signed multiplier with a registered product and an exact accumulator.
module bqd_mac #(
   parameter int A_BITS = 32,
   parameter int B_BITS = 32
) (
   input  logic                           clock,
   input  logic signed [A_BITS-1:0]       op_a,
   input  logic signed [B_BITS-1:0]       op_b,
   input  bqd_pkg::mac_ctl_type           ctl,
   output logic signed [A_BITS+B_BITS-1:0] prod_ff,
   output logic signed [A_BITS+B_BITS+2:0] acc_ff
);
   import bqd_pkg::*;

   localparam int P_BITS   = A_BITS + B_BITS;
   localparam int ACC_BITS = P_BITS + 3;

   logic signed [P_BITS-1:0]   prod_in;
   logic signed [ACC_BITS-1:0] acc_in;
   logic signed [ACC_BITS-1:0] prod_ext;

   assign prod_in  = P_BITS'(op_a) * P_BITS'(op_b);
   assign prod_ext = ACC_BITS'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.add) begin
         acc_in = acc_ff + prod_ext;
      end else if (ctl.sub) begin
         acc_in = acc_ff - prod_ext;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

endmodule

// File: sv/biquad_iir_filter_top.sv
// Biquad direct form I filter top level: sequencer, history, configuration and output stage.
// A filtered sample passes from its transfer on the request channel to its result in the
// response register through five multiply steps on the one shared multiplier, a final
// accumulate, a round and saturate step, a gain multiply on the same multiplier and a
// scale step. A new sample is taken only once the filter is back in idle after the
// previous result is loaded. With filter_on low a sample is answered in the next cycle
// with the input from two samples back. The response register holds one result while
// the next sample is taken; the scale step waits only if that register is still full.
// Coefficients are signed Q3.(COEF_BITS-4) and the gain is signed Q3.20. Configuration is
// to be written by the user only while the filter is idle; the block does not enforce it.
module biquad_iir_filter_top #(
   parameter int SAMPLE_BITS = 24,
   parameter int COEF_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   bqd_req_if.sink               req_ch,
   bqd_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [bqd_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [((COEF_BITS > bqd_pkg::GAIN_BITS) ? COEF_BITS : bqd_pkg::GAIN_BITS)-1:0]
                                 csr_wdata
);
   import bqd_pkg::*;

`include "biquad_iir_filter_top_assert.svh"

   localparam int HB        = SAMPLE_BITS + HIST_GUARD;
   localparam int MA        = (COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS;
   localparam int PW        = MA + HB;
   localparam int AW        = PW + 3;
   localparam int COEF_FRAC = COEF_BITS - COEF_INT_BITS;

   localparam logic signed [AW-1:0] ACC_HALF  = AW'(1) << (COEF_FRAC - 1);
   localparam logic signed [PW:0]   GAIN_HALF = (PW + 1)'(1) << (GAIN_FRAC - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAC,
      ST_ACC,
      ST_ROUND,
      ST_GAIN,
      ST_SCALE
   } state_type;

   // configuration
   logic                          filter_on_ff;
   logic signed [COEF_BITS-1:0]   coef_b0_ff, coef_b1_ff, coef_b2_ff, coef_a1_ff, coef_a2_ff;
   logic signed [GAIN_BITS-1:0]   out_gain_ff;

   // sequencer and history
   state_type                     state_ff, state_in;
   term_type                      term_ff, term_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] in_hist1_ff, in_hist1_in, in_hist2_ff, in_hist2_in;
   logic signed [HB-1:0]          out_hist1_ff, out_hist1_in, out_hist2_ff, out_hist2_in;
   logic signed [HB-1:0]          y_ff, y_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   // datapath
   logic signed [MA-1:0]          op_a;
   logic signed [HB-1:0]          op_b;
   mac_ctl_type                   mac_ctl;
   logic signed [PW-1:0]          prod;
   logic signed [AW-1:0]          acc;
   logic signed [AW-1:0]          acc_rnd, acc_shift;
   logic signed [HB-1:0]          y_sat;
   logic signed [PW:0]            gain_rnd, gain_shift;
   logic signed [SAMPLE_BITS-1:0] out_sat;
   logic                          req_xfer, out_free, scale_done;

   assign out_free      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready  = (state_ff == ST_IDLE) && (filter_on_ff || out_free);
   assign req_xfer      = req_ch.valid && req_ch.ready;
   assign scale_done    = (state_ff == ST_SCALE) && out_free;
   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.sample_out = rsp_data_ff;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_on_ff <= 1'b0;
         coef_b0_ff   <= '0;
         coef_b1_ff   <= '0;
         coef_b2_ff   <= '0;
         coef_a1_ff   <= '0;
         coef_a2_ff   <= '0;
         out_gain_ff  <= GAIN_RESET;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_FILTER_ON: filter_on_ff <= csr_wdata[0];
            REG_COEF_B0:   coef_b0_ff   <= csr_wdata[COEF_BITS-1:0];
            REG_COEF_B1:   coef_b1_ff   <= csr_wdata[COEF_BITS-1:0];
            REG_COEF_B2:   coef_b2_ff   <= csr_wdata[COEF_BITS-1:0];
            REG_COEF_A1:   coef_a1_ff   <= csr_wdata[COEF_BITS-1:0];
            REG_COEF_A2:   coef_a2_ff   <= csr_wdata[COEF_BITS-1:0];
            REG_OUT_GAIN:  out_gain_ff  <= csr_wdata[GAIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   // operand select for the shared multiplier; the gain product is the default
   always_comb begin
      op_a    = MA'(out_gain_ff);
      op_b    = y_ff;
      mac_ctl = '0;
      case (state_ff)
         ST_MAC: begin
            case (term_ff)
               TERM_B0: begin
                  op_a = MA'(coef_b0_ff);
                  op_b = HB'(x_ff);
                  mac_ctl.clear = 1'b1;
               end
               TERM_B1: begin
                  op_a = MA'(coef_b1_ff);
                  op_b = HB'(in_hist1_ff);
                  mac_ctl.add = 1'b1;
               end
               TERM_B2: begin
                  op_a = MA'(coef_b2_ff);
                  op_b = HB'(in_hist2_ff);
                  mac_ctl.add = 1'b1;
               end
               TERM_A1: begin
                  op_a = MA'(coef_a1_ff);
                  op_b = out_hist1_ff;
                  mac_ctl.add = 1'b1;
               end
               TERM_A2: begin
                  op_a = MA'(coef_a2_ff);
                  op_b = out_hist2_ff;
                  mac_ctl.sub = 1'b1;
               end
               default: ;
            endcase
         end
         ST_ACC:  mac_ctl.sub = 1'b1;
         default: ;
      endcase
   end

   bqd_mac #(
      .A_BITS (MA),
      .B_BITS (HB)
   ) u_mac (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .ctl     (mac_ctl),
      .prod_ff (prod),
      .acc_ff  (acc)
   );

   // round half up by the coefficient fraction, saturate to the history width
   always_comb begin
      acc_rnd   = acc + ACC_HALF;
      acc_shift = acc_rnd >>> COEF_FRAC;
      if (&acc_shift[AW-1:HB-1] || ~|acc_shift[AW-1:HB-1]) begin
         y_sat = acc_shift[HB-1:0];
      end else if (acc_shift[AW-1]) begin
         y_sat = {1'b1, {(HB-1){1'b0}}};
      end else begin
         y_sat = {1'b0, {(HB-1){1'b1}}};
      end
   end

   // scale by the gain, round half up, saturate to the sample width
   always_comb begin
      gain_rnd   = (PW + 1)'(prod) + GAIN_HALF;
      gain_shift = gain_rnd >>> GAIN_FRAC;
      if (&gain_shift[PW:SAMPLE_BITS-1] || ~|gain_shift[PW:SAMPLE_BITS-1]) begin
         out_sat = gain_shift[SAMPLE_BITS-1:0];
      end else if (gain_shift[PW]) begin
         out_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
      end else begin
         out_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      term_in      = term_ff;
      x_in         = x_ff;
      in_hist1_in  = in_hist1_ff;
      in_hist2_in  = in_hist2_ff;
      out_hist1_in = out_hist1_ff;
      out_hist2_in = out_hist2_ff;
      y_in         = y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (filter_on_ff) begin
                  x_in     = req_ch.sample_in;
                  term_in  = TERM_B0;
                  state_in = ST_MAC;
               end else begin
                  // bypass: answer with the oldest input, shift the input history only
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = in_hist2_ff;
                  in_hist2_in  = in_hist1_ff;
                  in_hist1_in  = req_ch.sample_in;
               end
            end
         end
         ST_MAC: begin
            if (term_ff == TERM_A2) begin
               state_in = ST_ACC;
            end else begin
               term_in = term_type'(term_ff + 3'd1);
            end
         end
         ST_ACC:   state_in = ST_ROUND;
         ST_ROUND: begin
            y_in     = y_sat;
            state_in = ST_GAIN;
         end
         ST_GAIN:  state_in = ST_SCALE;
         ST_SCALE: begin
            // hold until the response register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = out_sat;
               in_hist2_in  = in_hist1_ff;
               in_hist1_in  = x_ff;
               out_hist2_in = out_hist1_ff;
               out_hist1_in = y_ff;
               state_in     = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         term_ff      <= TERM_B0;
         in_hist1_ff  <= '0;
         in_hist2_ff  <= '0;
         out_hist1_ff <= '0;
         out_hist2_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         term_ff      <= term_in;
         in_hist1_ff  <= in_hist1_in;
         in_hist2_ff  <= in_hist2_in;
         out_hist1_ff <= out_hist1_in;
         out_hist2_ff <= out_hist2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      rsp_data_ff <= rsp_data_in;
   end

   `BQD_ASSERT_NEXT(a_filter_start, clock, reset, req_xfer && filter_on_ff, state_ff == ST_MAC, "filtered sample did not start the multiply sequence")
   `BQD_ASSERT_NEXT(a_scale_load, clock, reset, scale_done, rsp_valid_ff, "scale step finished without loading a response")
   `BQD_ASSERT_NEXT(a_hist_update, clock, reset, scale_done, (out_hist1_ff == $past(y_ff)) && (in_hist1_ff == $past(x_ff)), "history not advanced at the end of a filtered sample")
   `BQD_ASSERT_NOW(a_no_overwrite, clock, reset, rsp_valid_ff && !rsp_ch.ready, !(state_ff == ST_IDLE && req_xfer && !filter_on_ff) && !scale_done, "response register overwritten while waiting")

endmodule

// File: dv/biquad_iir_filter_top_tb.sv
// Self-checking testbench for the biquad filter top level: predicted samples, random handshakes.
`timescale 1ns / 1ps

module biquad_iir_filter_top_tb;
   import bqd_pkg::*;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

   localparam logic signed [31:0] COEF_MAX = 32'sh7fff_ffff;
   localparam logic signed [31:0] COEF_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] COEF_ONE = 32'sh1000_0000;
   localparam logic signed [23:0] SMP_MAX  = 24'sh7f_ffff;
   localparam logic signed [23:0] SMP_MIN  = 24'sh80_0000;
   localparam logic signed [23:0] GAIN_MAX = 24'sh7f_ffff;
   localparam logic signed [23:0] GAIN_MIN = 24'sh80_0000;
   localparam logic signed [23:0] GAIN_ONE = GAIN_RESET;

   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_ITEMS   = 100;

   typedef struct {
      logic              on;
      logic signed [31:0] b0, b1, b2, a1, a2;
      logic signed [23:0] gain;
   } filter_setting_type;

   // Mirror of the filter registers and history; holds the expected output samples.
   class biquad_checker;
      localparam logic signed [79:0] HIST_MAX = 80'sd2147483647;
      localparam logic signed [79:0] HIST_MIN = -80'sd2147483648;
      localparam logic signed [63:0] OUT_MAX  = 64'sd8388607;
      localparam logic signed [63:0] OUT_MIN  = -64'sd8388608;

      logic               on;
      logic signed [31:0] b0, b1, b2, a1, a2;
      logic signed [23:0] gain;
      logic signed [23:0] x1, x2;
      logic signed [31:0] y1, y2;
      logic signed [23:0] expected_samples[$];
      int                 fails;

      function new();
         on = 1'b0;
         b0 = '0; b1 = '0; b2 = '0; a1 = '0; a2 = '0;
         gain = GAIN_RESET;
         x1 = '0; x2 = '0; y1 = '0; y2 = '0;
         fails = 0;
      endfunction

      function void set_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] data);
         case (idx)
            REG_FILTER_ON: on = data[0];
            REG_COEF_B0:   b0 = data;
            REG_COEF_B1:   b1 = data;
            REG_COEF_B2:   b2 = data;
            REG_COEF_A1:   a1 = data;
            REG_COEF_A2:   a2 = data;
            REG_OUT_GAIN:  gain = data[23:0];
            default: ;
         endcase
      endfunction

      function logic signed [23:0] filter_step(logic signed [23:0] x);
         logic signed [79:0] acc;
         logic signed [31:0] y;
         logic signed [63:0] scaled;
         logic signed [23:0] res;
         if (!on) begin
            // Bypass: two-sample delay, output history held
            res = x2;
            x2 = x1;
            x1 = x;
            return res;
         end
         acc = b0 * x + b1 * x1 + b2 * x2 - a1 * y1 - a2 * y2;
         acc = (acc + 80'sd134217728) >>> 28;
         if (acc > HIST_MAX)      y = 32'sh7fff_ffff;
         else if (acc < HIST_MIN) y = 32'sh8000_0000;
         else                     y = acc[31:0];
         x2 = x1;
         x1 = x;
         y2 = y1;
         y1 = y;
         scaled = (y * gain + 64'sd524288) >>> 20;
         if (scaled > OUT_MAX)      res = 24'sh7f_ffff;
         else if (scaled < OUT_MIN) res = 24'sh80_0000;
         else                       res = scaled[23:0];
         return res;
      endfunction

      function void note_sample(logic signed [23:0] x);
         expected_samples.push_back(filter_step(x));
      endfunction

      function int pending();
         return expected_samples.size();
      endfunction

      task report(string msg);
         if (fails < 200) $display("[%0t] mismatch: %s", $time, msg);
         fails++;
      endtask

      task check_sample(logic signed [23:0] got);
         logic signed [23:0] want;
         if (expected_samples.size() == 0) begin
            report($sformatf("sample_out %0d with no sample pending", got));
            return;
         end
         want = expected_samples.pop_front();
         if (got !== want)
            report($sformatf("sample_out %0d, expected %0d", got, want));
      endtask
   endclass

   logic                      clock;
   logic                      reset;
   logic                      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [31:0]               csr_wdata;

   bqd_req_if #(.SAMPLE_BITS(24)) req_bus ();
   bqd_rsp_if #(.SAMPLE_BITS(24)) rsp_bus ();

   biquad_iir_filter_top #(
      .SAMPLE_BITS(24),
      .COEF_BITS  (32)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_bus),
      .rsp_ch   (rsp_bus),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   biquad_checker      sb;
   logic signed [23:0] stimulus_q[$];
   int                 gap_max    = 0;
   int                 stall_mode = 0;
   int                 hold_left  = 0;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("Regression FAIL");
      $finish;
   end

   // Receiver: long hold-off when asked, else stall on the phase's pattern
   initial begin
      int tick;
      tick = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         tick++;
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else begin
            case (stall_mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= 1'($urandom_range(0, 1));
               2: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
               default: rsp_bus.ready <= ((tick % 7) >= 3);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_sample(rsp_bus.sample_out);
   end

   task automatic csr_write(logic [CSR_INDEX_BITS-1:0] idx, logic [31:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // Write every register; junk in the unused upper bits must be dropped
   task automatic program_filter(filter_setting_type s);
      csr_write(REG_FILTER_ON, {31'($urandom), s.on});
      csr_write(REG_COEF_B0, s.b0);
      csr_write(REG_COEF_B1, s.b1);
      csr_write(REG_COEF_B2, s.b2);
      csr_write(REG_COEF_A1, s.a1);
      csr_write(REG_COEF_A2, s.a2);
      csr_write(REG_OUT_GAIN, {8'($urandom), s.gain});
      csr_we <= 1'b0;
   endtask

   // Send the queued samples in bursts; lower valid only when a gap follows or the queue is empty
   task automatic play_samples();
      int burst;
      int gap;
      while (stimulus_q.size() > 0) begin
         burst = $urandom_range(1, 16);
         while (burst > 0 && stimulus_q.size() > 0) begin
            req_bus.valid     <= 1'b1;
            req_bus.sample_in <= stimulus_q[0];
            do @(posedge clock); while (!req_bus.ready);
            sb.note_sample(stimulus_q.pop_front());
            burst--;
         end
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap > 0 || stimulus_q.size() == 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic wait_drain();
      while (sb.pending() > 0) @(posedge clock);
   endtask

   function automatic logic signed [23:0] pick_sample();
      int r;
      int v;
      r = $urandom_range(0, 9);
      if (r < 6) return 24'($urandom);
      if (r < 8) begin
         v = $urandom_range(0, 512);
         v = v - 256;
         return v[23:0];
      end
      case ($urandom_range(0, 3))
         0: return SMP_MAX;
         1: return SMP_MIN;
         2: return 24'sd0;
         default: return -24'sd1;
      endcase
   endfunction

   // kind 0: mostly stable, 1: anything, 2: extremes
   function automatic logic signed [31:0] pick_coef(int kind, reg_index_type role);
      int v;
      if (kind == 1) return $urandom;
      if (kind == 2) begin
         case ($urandom_range(0, 4))
            0: return COEF_MAX;
            1: return COEF_MIN;
            2: return 32'sd0;
            3: return COEF_ONE;
            default: return -COEF_ONE;
         endcase
      end
      case (role)
         REG_COEF_A1: begin
            v = $urandom_range(0, 1020054732);
            v = v - 510027366;
         end
         REG_COEF_A2: begin
            v = $urandom_range(0, 483183820);
            v = v - 241591910;
         end
         default: begin
            v = $urandom_range(0, 536870912);
            v = v - 268435456;
         end
      endcase
      return v;
   endfunction

   function automatic logic signed [23:0] pick_gain();
      int v;
      case ($urandom_range(0, 5))
         0: return GAIN_ONE;
         1: return 24'($urandom);
         2: return GAIN_MAX;
         3: return GAIN_MIN;
         4: return 24'sd0;
         default: begin
            v = $urandom_range(0, 2097152);
            v = v - 1048576;
            return v[23:0];
         end
      endcase
   endfunction

   initial begin
      filter_setting_type s;
      int kind;
      int r;
      sb = new();
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= REG_FILTER_ON;
      csr_wdata         <= '0;
      req_bus.valid     <= 1'b0;
      req_bus.sample_in <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset state: bypass, extremes and alternating bit patterns
      gap_max    = 3;
      stall_mode = 1;
      stimulus_q = '{SMP_MAX, SMP_MIN, 24'sd0, -24'sd1, 24'sh55_5555, 24'shaa_aaaa};
      play_samples();
      wait_drain();

      // Filter with all-zero coefficients; unused index must not disturb anything
      csr_write(REG_UNUSED, 32'hffff_ffff);
      s = '{1'b1, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, GAIN_ONE};
      program_filter(s);
      stimulus_q = '{SMP_MAX, SMP_MIN, -24'sd1};
      play_samples();
      wait_drain();

      // Runaway feedback: history and output both saturate
      s = '{1'b1, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MAX, GAIN_MAX};
      program_filter(s);
      stimulus_q = '{SMP_MAX, SMP_MAX, SMP_MAX, SMP_MIN, 24'sd0};
      play_samples();
      wait_drain();

      // Pass-through with most negative gain: output saturation and rounding
      s = '{1'b1, COEF_ONE, 32'sd0, 32'sd0, 32'sd0, 32'sd0, GAIN_MIN};
      program_filter(s);
      stimulus_q = '{SMP_MAX, SMP_MIN, 24'sd1, -24'sd1};
      play_samples();
      wait_drain();

      // Back to bypass mid-stream: output history held
      s.on = 1'b0;
      program_filter(s);
      stimulus_q = '{24'sd7, -24'sd9, SMP_MAX};
      play_samples();
      wait_drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         r = $urandom_range(0, 5);
         kind = (r < 3) ? 0 : ((r < 5) ? 1 : 2);
         s.on   = ($urandom_range(0, 3) != 0);
         s.b0   = pick_coef(kind, REG_COEF_B0);
         s.b1   = pick_coef(kind, REG_COEF_B1);
         s.b2   = pick_coef(kind, REG_COEF_B2);
         s.a1   = pick_coef(kind, REG_COEF_A1);
         s.a2   = pick_coef(kind, REG_COEF_A2);
         s.gain = pick_gain();
         program_filter(s);
         gap_max    = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
         stall_mode = $urandom_range(0, 3);
         // Hold off the response side long enough to back up the request side
         if (phase == 2) hold_left = 400;
         for (int i = 0; i < PHASE_ITEMS; i++) stimulus_q.push_back(pick_sample());
         play_samples();
         wait_drain();
      end

      repeat (12) @(posedge clock);
      if (sb.fails == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
